@@ hw/rtl/positional_sequential_list_defines.svh @@
// Assertion macros used by the list RTL.
`ifndef POSITIONAL_SEQUENTIAL_LIST_DEFINES_SVH
`define POSITIONAL_SEQUENTIAL_LIST_DEFINES_SVH

// Same-cycle implication.
`define PSL_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("list check failed");

// Next-cycle implication.
`define PSL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("list check failed");

`endif

@@ hw/rtl/psl_pkg.sv @@
package psl_pkg;

  localparam int PosW  = 8;
  localparam int OutW  = 32;
  localparam int CntW  = 8;
  localparam int StatW = 2;

  typedef enum logic [1:0] {
    CMD_READ   = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_ERASE  = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_e;

  localparam logic [StatW-1:0] ST_OK    = 2'd0;
  localparam logic [StatW-1:0] ST_RANGE = 2'd1;
  localparam logic [StatW-1:0] ST_FULL  = 2'd2;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INS,
    CELL_DEL
  } cell_op_e;

  // Broadcast to every cell; slot is the 0-based position.
  typedef struct packed {
    cell_op_e          op;
    logic [PosW-1:0]   slot;
  } cell_ctrl_t;

endpackage

@@ hw/rtl/psl_cell.sv @@
module psl_cell #(
  parameter int DATA_WIDTH = 32,
  parameter int IDX_W      = 8,
  parameter int INDEX      = 0
) (
  input  logic                   clk_i,
  input  psl_pkg::cell_ctrl_t    ctrl_i,
  input  logic [DATA_WIDTH-1:0]  value_i,
  input  logic [DATA_WIDTH-1:0]  left_i,
  input  logic [DATA_WIDTH-1:0]  right_i,
  output logic [DATA_WIDTH-1:0]  data_o,
  output logic [DATA_WIDTH-1:0]  tap_o
);
  import psl_pkg::*;

  logic [DATA_WIDTH-1:0] data_q, data_d;
  logic [IDX_W-1:0]      slot;
  logic                  hit, above;

  assign slot  = IDX_W'(ctrl_i.slot);
  assign hit   = (IDX_W'(INDEX) == slot);
  assign above = (IDX_W'(INDEX) > slot);

  always_comb begin
    data_d = data_q;
    case (ctrl_i.op)
      CELL_INS: begin
        if (hit) begin
          data_d = value_i;
        end else if (above) begin
          data_d = left_i;
        end
      end
      CELL_DEL: begin
        if (hit || above) begin
          data_d = right_i;
        end
      end
      default: data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
  // Only the addressed cell drives the read bus.
  assign tap_o  = hit ? data_q : '0;

endmodule

@@ hw/rtl/psl_gather.sv @@
module psl_gather #(
  parameter int CAPACITY   = 128,
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk_i,
  input  logic                  load_i,
  input  logic [DATA_WIDTH-1:0] taps_i [CAPACITY],
  output logic [DATA_WIDTH-1:0] word_o
);
  localparam int Group  = 16;
  localparam int Groups = (CAPACITY + Group - 1) / Group;

  logic [DATA_WIDTH-1:0] grp_q [Groups];
  logic [DATA_WIDTH-1:0] grp_d [Groups];

  always_comb begin
    for (int g = 0; g < Groups; g++) begin
      grp_d[g] = '0;
      for (int m = 0; m < Group; m++) begin
        if (g * Group + m < CAPACITY) begin
          grp_d[g] = grp_d[g] | taps_i[g * Group + m];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      for (int g = 0; g < Groups; g++) begin
        grp_q[g] <= grp_d[g];
      end
    end
  end

  always_comb begin
    word_o = '0;
    for (int g = 0; g < Groups; g++) begin
      word_o = word_o | grp_q[g];
    end
  end

endmodule

@@ hw/rtl/positional_sequential_list.sv @@
// Channel   Handshake                  Payload
// command   in_valid_i / in_stall_o    cmd_i, position_i, value_i
// result    out_valid_o / out_stall_i  status_o, element_o, count_o
//
// One command per cycle while in_stall_o is low; results pass the middle
// stage and the output registers. On insert or erase, cells from the addressed
// slot up update in the accept cycle; reads use a registered OR tree of cells.
// Reset clears the length and the valid flags; cell contents are not reset.
// A stalled result holds the middle stage, which then stalls the command side.
module positional_sequential_list #(
  parameter int CAPACITY   = 128,
  parameter int DATA_WIDTH = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [1:0]                   cmd_i,
  input  logic [psl_pkg::PosW-1:0]     position_i,
  input  logic signed [psl_pkg::OutW-1:0] value_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [psl_pkg::StatW-1:0]    status_o,
  output logic signed [psl_pkg::OutW-1:0] element_o,
  output logic [psl_pkg::CntW-1:0]     count_o
);
  import psl_pkg::*;

  `include "positional_sequential_list_defines.svh"

  localparam int LenW  = $clog2(CAPACITY + 1);
  localparam int IdxW  = ($clog2(CAPACITY) > PosW) ? $clog2(CAPACITY) : PosW;
  localparam int CmpW  = ((LenW > PosW) ? LenW : PosW) + 1;

  logic [LenW-1:0]       length_q, length_d;
  logic                  accept, s1_adv;
  logic                  s1_valid_q;
  logic [StatW-1:0]      s1_status_q, status_d;
  logic                  s1_elem_q, elem_d;
  logic [CntW-1:0]       s1_count_q;
  logic                  out_valid_q;
  logic [StatW-1:0]      status_q;
  logic [OutW-1:0]       element_q;
  logic [CntW-1:0]       count_q;

  logic [CmpW-1:0]       pos_c, len_c;
  logic                  pos_nz, in_list, in_ins, full;
  cell_ctrl_t            ctrl;
  logic [DATA_WIDTH-1:0] value_w, word, cell_data [CAPACITY], taps [CAPACITY];
  logic [OutW-1:0]       word_ext;

  assign s1_adv     = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign accept     = in_valid_i && !in_stall_o;

  assign pos_c   = CmpW'(position_i);
  assign len_c   = CmpW'(length_q);
  assign pos_nz  = (pos_c != '0);
  assign in_list = pos_nz && (pos_c <= len_c);
  assign in_ins  = pos_nz && (pos_c <= len_c + CmpW'(1));
  assign full    = (length_q == LenW'(CAPACITY));

  always_comb begin
    length_d  = length_q;
    status_d  = ST_OK;
    elem_d    = 1'b0;
    ctrl.op   = CELL_HOLD;
    ctrl.slot = position_i - PosW'(1);
    if (accept) begin
      unique case (cmd_e'(cmd_i))
        CMD_READ: begin
          if (in_list) begin
            elem_d = 1'b1;
          end else begin
            status_d = ST_RANGE;
          end
        end
        CMD_INSERT: begin
          if (!in_ins) begin
            status_d = ST_RANGE;
          end else if (full) begin
            status_d = ST_FULL;
          end else begin
            ctrl.op  = CELL_INS;
            length_d = length_q + LenW'(1);
          end
        end
        CMD_ERASE: begin
          if (in_list) begin
            elem_d   = 1'b1;
            ctrl.op  = CELL_DEL;
            length_d = length_q - LenW'(1);
          end else begin
            status_d = ST_RANGE;
          end
        end
        CMD_CLEAR: length_d = '0;
        default:   length_d = length_q;
      endcase
    end
  end

  // Fit the 32-bit input to the stored width and stored words back to 32 bits.
  if (DATA_WIDTH <= OutW) begin : g_narrow
    assign value_w  = value_i[DATA_WIDTH-1:0];
    assign word_ext = {{(OutW - DATA_WIDTH){word[DATA_WIDTH-1]}}, word};
  end else begin : g_wide
    assign value_w  = {{(DATA_WIDTH - OutW){value_i[OutW-1]}}, value_i};
    assign word_ext = word[OutW-1:0];
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] left, right;
    if (i == 0) begin : g_first
      assign left = cell_data[i];
    end else begin : g_mid_l
      assign left = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right = cell_data[i];
    end else begin : g_mid_r
      assign right = cell_data[i+1];
    end
    psl_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .IDX_W      (IdxW),
      .INDEX      (i)
    ) u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .value_i (value_w),
      .left_i  (left),
      .right_i (right),
      .data_o  (cell_data[i]),
      .tap_o   (taps[i])
    );
  end

  psl_gather #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_gather (
    .clk_i  (clk_i),
    .load_i (accept),
    .taps_i (taps),
    .word_o (word)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      length_q    <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      length_q <= length_d;
      if (s1_adv) begin
        out_valid_q <= s1_valid_q;
      end
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_status_q <= status_d;
      s1_elem_q   <= elem_d;
      s1_count_q  <= CntW'(length_d);
    end
    if (s1_adv && s1_valid_q) begin
      status_q  <= s1_status_q;
      element_q <= s1_elem_q ? word_ext : '0;
      count_q   <= s1_count_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign element_o   = element_q;
  assign count_o     = count_q;

  `PSL_ASSERT_NOW(a_len_cap, clk_i, rst_ni, 1'b1, length_q <= LenW'(CAPACITY))
  `PSL_ASSERT_NEXT(a_clear_len, clk_i, rst_ni, accept && cmd_i == CMD_CLEAR, length_q == '0)
  `PSL_ASSERT_NOW(a_err_elem, clk_i, rst_ni, out_valid_q && status_q != ST_OK, element_q == '0)
  `PSL_ASSERT_NOW(a_full_cnt, clk_i, rst_ni, out_valid_q && status_q == ST_FULL,
                  count_q == CntW'(CAPACITY))

endmodule
